// ----- hdl/mmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mmpc_pkg
// Shared types, mode codes and helpers for the RGBA pixel combine pipeline.
// ----------------------------------------------------------------------------
package mmpc_pkg;

   localparam int ChanW = 8;
   localparam int ModeW = 4;
   localparam int ProdW = 2 * ChanW;

   // blend_mode codes
   localparam logic [ModeW-1:0] MODE_ADD_CLAMP = 4'd0;
   localparam logic [ModeW-1:0] MODE_ADD_WRAP  = 4'd1;
   localparam logic [ModeW-1:0] MODE_SUB_CLAMP = 4'd2;
   localparam logic [ModeW-1:0] MODE_SUB_WRAP  = 4'd3;
   localparam logic [ModeW-1:0] MODE_MUL       = 4'd4;
   localparam logic [ModeW-1:0] MODE_MUL_X2    = 4'd5;
   localparam logic [ModeW-1:0] MODE_BLEND     = 4'd6;
   localparam logic [ModeW-1:0] MODE_ALPHA     = 4'd7;
   localparam logic [ModeW-1:0] MODE_LAYER     = 4'd8;

   // register indexes
   localparam logic [1:0] REG_BLEND_MODE    = 2'd0;
   localparam logic [1:0] REG_RED_PERCENT   = 2'd1;
   localparam logic [1:0] REG_GREEN_PERCENT = 2'd2;
   localparam logic [1:0] REG_BLUE_PERCENT  = 2'd3;

   localparam logic [ModeW-1:0] MODE_RESET    = MODE_LAYER;
   localparam logic [ChanW-1:0] PERCENT_RESET = 8'd255;

   // pipeline control handed to each lane; mode and present belong to the
   // beat sitting in the last compute stage
   typedef struct packed {
      logic             advance;
      logic [ModeW-1:0] mode;
      logic             present;
   } mmpc_ctl_type;

   // exact floor(x / 255) for x <= 65025
   function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
      logic [ProdW:0] acc;
      acc = {1'b0, x} + {{ProdW{1'b0}}, 1'b1} + {{(ChanW+1){1'b0}}, x[ProdW-1:ChanW]};
      return acc[ProdW-1:ChanW];
   endfunction

endpackage

// ----- hdl/multi_mode_pixel_combine.sv -----
// ----------------------------------------------------------------------------
// multi_mode_pixel_combine
// Combines a destination and a source RGBA pixel under a selectable mode.
// ----------------------------------------------------------------------------
// Takes one destination/source pixel pair per clock through three register
// stages (input products, combine, select into the output register). The
// combined pixel shows on the response port once it sits in the output
// register. Throughput is one pixel per cycle; the pipeline only holds when
// a finished pixel sits in the output register with rsp_stall high, and
// req_stall then follows. Registers are written through csr_we, csr_index
// and csr_wdata and must only change while no beat is in flight.
module multi_mode_pixel_combine
   import mmpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [ChanW-1:0] csr_wdata,

   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ChanW-1:0] req_dst_red,
   input  logic [ChanW-1:0] req_dst_green,
   input  logic [ChanW-1:0] req_dst_blue,
   input  logic [ChanW-1:0] req_dst_alpha,
   input  logic [ChanW-1:0] req_src_red,
   input  logic [ChanW-1:0] req_src_green,
   input  logic [ChanW-1:0] req_src_blue,
   input  logic [ChanW-1:0] req_src_alpha,
   input  logic             req_source_present,

   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ChanW-1:0] rsp_out_red,
   output logic [ChanW-1:0] rsp_out_green,
   output logic [ChanW-1:0] rsp_out_blue,
   output logic [ChanW-1:0] rsp_out_alpha
);

   // configuration registers
   logic [ModeW-1:0] blend_mode_ff;
   logic [ChanW-1:0] red_pct_ff, green_pct_ff, blue_pct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= MODE_RESET;
         red_pct_ff    <= PERCENT_RESET;
         green_pct_ff  <= PERCENT_RESET;
         blue_pct_ff   <= PERCENT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_BLEND_MODE:    blend_mode_ff <= csr_wdata[ModeW-1:0];
            REG_RED_PERCENT:   red_pct_ff    <= csr_wdata;
            REG_GREEN_PERCENT: green_pct_ff  <= csr_wdata;
            REG_BLUE_PERCENT:  blue_pct_ff   <= csr_wdata;
            default:           blend_mode_ff <= blend_mode_ff;
         endcase
      end
   end

   // pipeline control
   logic advance;
   logic req_take;
   logic v1_ff, v2_ff, rsp_valid_ff;
   logic [ModeW-1:0] mode_s1_ff, mode_s2_ff;
   logic present_s1_ff, present_s2_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign req_take  = req_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_s1_ff    <= blend_mode_ff;
         present_s1_ff <= req_source_present;
         mode_s2_ff    <= mode_s1_ff;
         present_s2_ff <= present_s1_ff;
      end
   end

   mmpc_ctl_type ctl;
   logic [ChanW-1:0] inv_alpha;

   assign ctl.advance = advance;
   assign ctl.mode    = mode_s2_ff;
   assign ctl.present = present_s2_ff;
   assign inv_alpha   = 8'd255 - req_src_alpha;

   mmpc_lane u_lane_red (
      .clock     (clock),
      .ctl       (ctl),
      .dst       (req_dst_red),
      .src       (req_src_red),
      .pct       (red_pct_ff),
      .src_alpha (req_src_alpha),
      .inv_alpha (inv_alpha),
      .result    (rsp_out_red)
   );

   mmpc_lane u_lane_green (
      .clock     (clock),
      .ctl       (ctl),
      .dst       (req_dst_green),
      .src       (req_src_green),
      .pct       (green_pct_ff),
      .src_alpha (req_src_alpha),
      .inv_alpha (inv_alpha),
      .result    (rsp_out_green)
   );

   mmpc_lane u_lane_blue (
      .clock     (clock),
      .ctl       (ctl),
      .dst       (req_dst_blue),
      .src       (req_src_blue),
      .pct       (blue_pct_ff),
      .src_alpha (req_src_alpha),
      .inv_alpha (inv_alpha),
      .result    (rsp_out_blue)
   );

   // alpha path
   logic [ChanW-1:0] da_s1_ff, sas_s1_ff;
   logic [ProdW-1:0] a_prod_s1_ff, a_src_s1_ff;
   logic [ProdW-1:0] a_scale_in, a_prod_in, a_src_in;

   assign a_scale_in = ProdW'(req_src_alpha) * ProdW'(blue_pct_ff);
   assign a_prod_in  = ProdW'(req_dst_alpha) * ProdW'(inv_alpha);
   // sa * 255
   assign a_src_in   = {req_src_alpha, {ChanW{1'b0}}} - ProdW'(req_src_alpha);

   always_ff @(posedge clock) begin
      if (advance) begin
         da_s1_ff     <= req_dst_alpha;
         sas_s1_ff    <= a_scale_in[ProdW-1:ChanW];
         a_prod_s1_ff <= a_prod_in;
         a_src_s1_ff  <= a_src_in;
      end
   end

   logic [ChanW-1:0] da_s2_ff, a_avg_s2_ff;
   logic [ProdW-1:0] a_lay_s2_ff;
   logic [ChanW:0]   a_sum_in;

   assign a_sum_in = {1'b0, da_s1_ff} + {1'b0, sas_s1_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         da_s2_ff    <= da_s1_ff;
         a_avg_s2_ff <= a_sum_in[ChanW:1];
         a_lay_s2_ff <= a_prod_s1_ff + a_src_s1_ff;
      end
   end

   logic [ChanW-1:0] alpha_ff, alpha_in;

   always_comb begin
      alpha_in = da_s2_ff;
      if (present_s2_ff) begin
         case (mode_s2_ff)
            MODE_ALPHA: alpha_in = a_avg_s2_ff;
            MODE_LAYER: alpha_in = div255(a_lay_s2_ff);
            default:    alpha_in = da_s2_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         alpha_ff <= alpha_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_alpha = alpha_ff;

   // checks
   a_take_enters: assert property (@(posedge clock) disable iff (reset)
      req_take |=> v1_ff)
      else $error("accepted beat did not enter stage 1");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(v1_ff) && $stable(v2_ff) && $stable(mode_s2_ff))
      else $error("pipeline moved while held");

   a_drain_to_out: assert property (@(posedge clock) disable iff (reset)
      (advance && v2_ff) |=> rsp_valid_ff)
      else $error("stage 2 beat lost before output");

endmodule

// ----- hdl/mmpc_lane.sv -----
// ----------------------------------------------------------------------------
// mmpc_lane
// One color channel of the combine pipeline: scale, combine, select.
// ----------------------------------------------------------------------------
module mmpc_lane
   import mmpc_pkg::*;
(
   input  logic             clock,
   input  mmpc_ctl_type     ctl,
   input  logic [ChanW-1:0] dst,
   input  logic [ChanW-1:0] src,
   input  logic [ChanW-1:0] pct,
   input  logic [ChanW-1:0] src_alpha,
   input  logic [ChanW-1:0] inv_alpha,
   output logic [ChanW-1:0] result
);

   // stage 1: products
   logic [ChanW-1:0] d_s1_ff, s_s1_ff;
   logic [ProdW-1:0] lay_a_s1_ff, lay_b_s1_ff;
   logic [ProdW-1:0] scale_prod_in;
   logic [ProdW-1:0] lay_a_in, lay_b_in;

   assign scale_prod_in = ProdW'(src) * ProdW'(pct);
   assign lay_a_in      = ProdW'(src) * ProdW'(src_alpha);
   assign lay_b_in      = ProdW'(dst) * ProdW'(inv_alpha);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         d_s1_ff     <= dst;
         s_s1_ff     <= scale_prod_in[ProdW-1:ChanW];
         lay_a_s1_ff <= lay_a_in;
         lay_b_s1_ff <= lay_b_in;
      end
   end

   // stage 2: second product, sums and difference
   logic [ChanW-1:0] d_s2_ff;
   logic [ChanW:0]   sum_s2_ff, diff_s2_ff;
   logic [ProdW-1:0] mul_s2_ff, lay_s2_ff;
   logic [ProdW-1:0] mul_in;

   assign mul_in = ProdW'(d_s1_ff) * ProdW'(s_s1_ff);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         d_s2_ff    <= d_s1_ff;
         sum_s2_ff  <= {1'b0, d_s1_ff} + {1'b0, s_s1_ff};
         diff_s2_ff <= {1'b0, d_s1_ff} - {1'b0, s_s1_ff};
         mul_s2_ff  <= mul_in;
         lay_s2_ff  <= lay_a_s1_ff + lay_b_s1_ff;
      end
   end

   // stage 3: finish and select
   logic [ChanW-1:0] result_ff, result_in;

   always_comb begin
      result_in = d_s2_ff;
      if (ctl.present) begin
         case (ctl.mode)
            MODE_ADD_CLAMP: result_in = sum_s2_ff[ChanW] ? 8'd255 : sum_s2_ff[ChanW-1:0];
            MODE_ADD_WRAP: begin
               if (sum_s2_ff == 9'd510)
                  result_in = '0;
               else if (sum_s2_ff >= 9'd255)
                  result_in = ChanW'(sum_s2_ff - 9'd255);
               else
                  result_in = sum_s2_ff[ChanW-1:0];
            end
            MODE_SUB_CLAMP: result_in = diff_s2_ff[ChanW] ? '0 : diff_s2_ff[ChanW-1:0];
            // 2^32 is 1 mod 255, so the 32-bit wrap folds into the low byte
            MODE_SUB_WRAP: result_in = (diff_s2_ff[ChanW-1:0] == 8'd255) ? '0
                                                                        : diff_s2_ff[ChanW-1:0];
            MODE_MUL:    result_in = mul_s2_ff[ProdW-1:ChanW];
            MODE_MUL_X2: result_in = mul_s2_ff[ProdW-1] ? 8'd255 : mul_s2_ff[ProdW-2:ChanW-1];
            MODE_BLEND:  result_in = sum_s2_ff[ChanW:1];
            MODE_LAYER:  result_in = div255(lay_s2_ff);
            default:     result_in = d_s2_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-mode RGBA pixel combine pipeline.
// ----------------------------------------------------------------------------
// Pixel pairs go in through the request channel. A behavioral copy of the
// combine rules, with its own copy of the mode and percent registers, works
// out the expected pixel for every accepted beat and queues it. A checker
// process compares each response beat field by field against the oldest
// queued pixel. Directed cases cover reset values, every mode, undefined
// modes, stray high mode bits and percent extremes. A receiver hold-off
// backs up the pipe, and random phases sweep register settings.
// ----------------------------------------------------------------------------
module testbench
   import mmpc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = 3;
   localparam int LONG_HOLD    = 40;
   localparam int PHASE_COUNT  = 13;
   localparam int PHASE_BEATS  = 100;
   localparam int unsigned CHAN_MAX = 255;
   localparam logic [ModeW-1:0] MODE_UNDEF_LO = 4'd9;
   localparam logic [ModeW-1:0] MODE_UNDEF_HI = 4'd15;

   typedef struct {
      logic [ChanW-1:0] dst_red;
      logic [ChanW-1:0] dst_green;
      logic [ChanW-1:0] dst_blue;
      logic [ChanW-1:0] dst_alpha;
      logic [ChanW-1:0] src_red;
      logic [ChanW-1:0] src_green;
      logic [ChanW-1:0] src_blue;
      logic [ChanW-1:0] src_alpha;
      logic             present;
   } pixel_pair_type;

   typedef struct {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
      logic [ChanW-1:0] alpha;
   } rgba_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [1:0]       csr_index;
   logic [ChanW-1:0] csr_wdata;
   logic             req_valid;
   logic             req_stall;
   logic [ChanW-1:0] req_dst_red;
   logic [ChanW-1:0] req_dst_green;
   logic [ChanW-1:0] req_dst_blue;
   logic [ChanW-1:0] req_dst_alpha;
   logic [ChanW-1:0] req_src_red;
   logic [ChanW-1:0] req_src_green;
   logic [ChanW-1:0] req_src_blue;
   logic [ChanW-1:0] req_src_alpha;
   logic             req_source_present;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [ChanW-1:0] rsp_out_red;
   logic [ChanW-1:0] rsp_out_green;
   logic [ChanW-1:0] rsp_out_blue;
   logic [ChanW-1:0] rsp_out_alpha;

   // register shadow
   logic [ModeW-1:0] cfg_mode;
   logic [ChanW-1:0] cfg_red_pct;
   logic [ChanW-1:0] cfg_green_pct;
   logic [ChanW-1:0] cfg_blue_pct;

   rgba_type    pending_pixels[$];
   int          error_count;
   bit          sender_gaps;
   bit          stall_enable;
   int unsigned hold_request;
   int unsigned hold_left;
   int unsigned run_left;

   multi_mode_pixel_combine u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dst_red        (req_dst_red),
      .req_dst_green      (req_dst_green),
      .req_dst_blue       (req_dst_blue),
      .req_dst_alpha      (req_dst_alpha),
      .req_src_red        (req_src_red),
      .req_src_green      (req_src_green),
      .req_src_blue       (req_src_blue),
      .req_src_alpha      (req_src_alpha),
      .req_source_present (req_source_present),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_red        (rsp_out_red),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_out_alpha      (rsp_out_alpha)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned scale_source(int unsigned s, int unsigned pct);
      return (s * pct) >> 8;
   endfunction

   function automatic logic [ChanW-1:0] combine_channel(logic [ModeW-1:0] mode,
                                                        int unsigned d, int unsigned s);
      int unsigned t;
      case (mode)
         MODE_ADD_CLAMP: begin
            t = d + s;
            return (t < CHAN_MAX) ? t[ChanW-1:0] : CHAN_MAX[ChanW-1:0];
         end
         MODE_ADD_WRAP: begin
            t = (d + s) % CHAN_MAX;
            return t[ChanW-1:0];
         end
         MODE_SUB_CLAMP: begin
            t = (d > s) ? d - s : 0;
            return t[ChanW-1:0];
         end
         MODE_SUB_WRAP: begin
            // 32-bit wrap first, then mod 255
            t = d - s;
            t = t % CHAN_MAX;
            return t[ChanW-1:0];
         end
         MODE_MUL: begin
            t = (d * s) >> 8;
            return t[ChanW-1:0];
         end
         MODE_MUL_X2: begin
            t = (d * s) >> 7;
            return (t < CHAN_MAX) ? t[ChanW-1:0] : CHAN_MAX[ChanW-1:0];
         end
         MODE_BLEND: begin
            t = (d + s) >> 1;
            return t[ChanW-1:0];
         end
         default: return d[ChanW-1:0];
      endcase
   endfunction

   function automatic rgba_type combine_pixel(pixel_pair_type p);
      rgba_type    o;
      int unsigned dr, dg, db, da, sr, sg, sb, sa, inv, t;
      dr = 32'(p.dst_red);   dg = 32'(p.dst_green);
      db = 32'(p.dst_blue);  da = 32'(p.dst_alpha);
      sr = 32'(p.src_red);   sg = 32'(p.src_green);
      sb = 32'(p.src_blue);  sa = 32'(p.src_alpha);
      o.red = p.dst_red;
      o.green = p.dst_green;
      o.blue = p.dst_blue;
      o.alpha = p.dst_alpha;
      if (p.present) begin
         if (cfg_mode <= MODE_BLEND) begin
            o.red   = combine_channel(cfg_mode, dr, scale_source(sr, 32'(cfg_red_pct)));
            o.green = combine_channel(cfg_mode, dg, scale_source(sg, 32'(cfg_green_pct)));
            o.blue  = combine_channel(cfg_mode, db, scale_source(sb, 32'(cfg_blue_pct)));
         end else if (cfg_mode == MODE_ALPHA) begin
            t = (da + scale_source(sa, 32'(cfg_blue_pct))) >> 1;
            o.alpha = t[ChanW-1:0];
         end else if (cfg_mode == MODE_LAYER) begin
            inv = CHAN_MAX - sa;
            t = (da * inv + sa * CHAN_MAX) / CHAN_MAX;  o.alpha = t[ChanW-1:0];
            t = (sr * sa + dr * inv) / CHAN_MAX;        o.red   = t[ChanW-1:0];
            t = (sg * sa + dg * inv) / CHAN_MAX;        o.green = t[ChanW-1:0];
            t = (sb * sa + db * inv) / CHAN_MAX;        o.blue  = t[ChanW-1:0];
         end
      end
      return o;
   endfunction

   // ---------------------------------------------------------------- random helpers

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ChanW-1:0] rand_chan();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return 8'($urandom_range(0, CHAN_MAX));
   endfunction

   function automatic logic [ChanW-1:0] rand_percent();
      int unsigned roll;
      roll = $urandom_range(0, 3);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return 8'($urandom_range(0, CHAN_MAX));
   endfunction

   function automatic pixel_pair_type make_pixel(logic [ChanW-1:0] dr, dg, db, da,
                                                 logic [ChanW-1:0] sr, sg, sb, sa,
                                                 logic present);
      pixel_pair_type p;
      p.dst_red = dr;  p.dst_green = dg;  p.dst_blue = db;  p.dst_alpha = da;
      p.src_red = sr;  p.src_green = sg;  p.src_blue = sb;  p.src_alpha = sa;
      p.present = present;
      return p;
   endfunction

   function automatic pixel_pair_type rand_pixel();
      return make_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                        rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                        $urandom_range(0, 9) != 0);
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_pixel(input pixel_pair_type p);
      int unsigned gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_dst_red        <= p.dst_red;
      req_dst_green      <= p.dst_green;
      req_dst_blue       <= p.dst_blue;
      req_dst_alpha      <= p.dst_alpha;
      req_src_red        <= p.src_red;
      req_src_green      <= p.src_green;
      req_src_blue       <= p.src_blue;
      req_src_alpha      <= p.src_alpha;
      req_source_present <= p.present;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_pixels.push_back(combine_pixel(p));
   endtask

   // wait until every queued pixel has come back, then let the pipe settle
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic set_config(input logic [ChanW-1:0] mode_word, red_pct, green_pct,
                             blue_pct);
      csr_we    <= 1'b1;
      csr_index <= REG_BLEND_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      csr_index <= REG_RED_PERCENT;
      csr_wdata <= red_pct;
      @(posedge clock);
      csr_index <= REG_GREEN_PERCENT;
      csr_wdata <= green_pct;
      @(posedge clock);
      csr_index <= REG_BLUE_PERCENT;
      csr_wdata <= blue_pct;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cfg_mode      = mode_word[ModeW-1:0];
      cfg_red_pct   = red_pct;
      cfg_green_pct = green_pct;
      cfg_blue_pct  = blue_pct;
   endtask

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!stall_enable) begin
         rsp_stall <= 1'b0;
      end else if (run_left != 0) begin
         run_left--;
      end else begin
         rsp_stall <= !rsp_stall;
         run_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      rgba_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result beat: %0d %0d %0d %0d", rsp_out_red,
                        rsp_out_green, rsp_out_blue, rsp_out_alpha);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out_red !== want.red || rsp_out_green !== want.green ||
                rsp_out_blue !== want.blue || rsp_out_alpha !== want.alpha) begin
               if (error_count < 10)
                  $display("pixel mismatch (mode %0d): ", cfg_mode,
                           "rgba expected %0d %0d %0d %0d, ",
                           want.red, want.green, want.blue, want.alpha,
                           "got %0d %0d %0d %0d",
                           rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // registers come up as layer mode with full percents
   task automatic test_reset_state();
      cfg_mode      = MODE_RESET;
      cfg_red_pct   = PERCENT_RESET;
      cfg_green_pct = PERCENT_RESET;
      cfg_blue_pct  = PERCENT_RESET;
      send_pixel(make_pixel(12, 34, 56, 78, '1, '1, '1, '0, 1'b1));
      send_pixel(make_pixel(12, 34, 56, 78, 200, 100, 50, '1, 1'b1));
      send_pixel(make_pixel('1, '0, 90, 10, '0, '1, 170, 128, 1'b1));
      send_pixel(make_pixel(1, 2, 3, 4, '1, '1, '1, '1, 1'b0));
      send_pixel(make_pixel('0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
      drain_pipeline();
   endtask

   task automatic test_each_mode();
      logic [ModeW-1:0] colour_modes [7];
      colour_modes = '{MODE_ADD_CLAMP, MODE_ADD_WRAP, MODE_SUB_CLAMP, MODE_SUB_WRAP,
                       MODE_MUL, MODE_MUL_X2, MODE_BLEND};
      foreach (colour_modes[i]) begin
         set_config({4'h0, colour_modes[i]}, '1, '1, '1);
         // saturating sum, floor-clamped difference and wrap all in one pixel
         send_pixel(make_pixel('1, '0, '1, '0, '1, '1, '0, '1, 1'b1));
         drain_pipeline();
      end
      set_config({4'h0, MODE_ALPHA}, '1, '1, '1);
      send_pixel(make_pixel(10, 20, 30, '1, 40, 50, 60, '1, 1'b1));
      drain_pipeline();
      set_config({4'h0, MODE_ALPHA}, '1, '1, '0);
      send_pixel(make_pixel(10, 20, 30, '1, 40, 50, 60, '1, 1'b1));
      drain_pipeline();
      // zero percents wipe the source
      set_config({4'h0, MODE_ADD_CLAMP}, '0, '0, '0);
      send_pixel(make_pixel(100, 150, 200, 250, '1, '1, '1, '1, 1'b1));
      drain_pipeline();
   endtask

   task automatic test_undefined_modes();
      set_config({4'h0, MODE_UNDEF_LO}, '1, '1, '1);
      send_pixel(make_pixel(11, 22, 33, 44, '1, '1, '1, '1, 1'b1));
      drain_pipeline();
      set_config('1, 128, 64, 32);
      send_pixel(make_pixel('1, '0, '1, '0, '1, '1, '1, '1, 1'b1));
      drain_pipeline();
      // upper nibble of the mode write must be dropped
      set_config({4'hF, MODE_SUB_WRAP}, '1, '1, '1);
      send_pixel(make_pixel('0, '0, '0, '0, '1, '1, '1, '1, 1'b1));
      drain_pipeline();
   endtask

   task automatic test_backpressure();
      int n;
      set_config({4'h0, MODE_MUL_X2}, rand_percent(), rand_percent(), rand_percent());
      sender_gaps  = 0;
      stall_enable = 0;
      hold_request = LONG_HOLD;
      for (n = 0; n < 24; n++) send_pixel(rand_pixel());
      drain_pipeline();
      set_config({4'h0, MODE_LAYER}, rand_percent(), rand_percent(), rand_percent());
      sender_gaps  = 1;
      stall_enable = 1;
      for (n = 0; n < 24; n++) begin
         if (n == 6) hold_request = LONG_HOLD;
         send_pixel(rand_pixel());
      end
      drain_pipeline();
   endtask

   task automatic test_random_mix();
      logic [ModeW-1:0] mode_list [9];
      logic [ModeW-1:0] mode;
      int phase, n;
      mode_list = '{MODE_ADD_CLAMP, MODE_ADD_WRAP, MODE_SUB_CLAMP, MODE_SUB_WRAP,
                    MODE_MUL, MODE_MUL_X2, MODE_BLEND, MODE_ALPHA, MODE_LAYER};
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 9) mode = mode_list[phase];
         else if (phase == 9) mode = 4'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
         else mode = 4'($urandom_range(0, MODE_UNDEF_HI));
         set_config({4'($urandom_range(0, MODE_UNDEF_HI)), mode},
                    rand_percent(), rand_percent(), rand_percent());
         // one phase runs flat out on both sides
         sender_gaps  = (phase != 2);
         stall_enable = (phase != 2);
         for (n = 0; n < PHASE_BEATS; n++) begin
            send_pixel(rand_pixel());
            if ($urandom_range(0, 149) == 0) drain_pipeline();
         end
         drain_pipeline();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = REG_BLEND_MODE;
      csr_wdata          = '0;
      req_valid          = 1'b0;
      req_dst_red        = '0;
      req_dst_green      = '0;
      req_dst_blue       = '0;
      req_dst_alpha      = '0;
      req_src_red        = '0;
      req_src_green      = '0;
      req_src_blue       = '0;
      req_src_alpha      = '0;
      req_source_present = 1'b0;
      rsp_stall          = 1'b0;
      error_count        = 0;
      sender_gaps        = 1'b1;
      stall_enable       = 1'b1;
      hold_request       = 0;
      hold_left          = 0;
      run_left           = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_each_mode();
      test_undefined_modes();
      test_backpressure();
      test_random_mix();

      req_valid <= 1'b0;
      for (int i = 0; i < 2000 && pending_pixels.size() != 0; i++) @(posedge clock);
      error_count += pending_pixels.size();
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      if (error_count == 0) begin
         $display("[multi_mode_pixel_combine] OK");
      end else begin
         $display("[multi_mode_pixel_combine] ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[multi_mode_pixel_combine] ERROR");
      $finish;
   end

endmodule

// ----- multi_mode_pixel_combine.f -----
hdl/mmpc_pkg.sv
hdl/mmpc_lane.sv
hdl/multi_mode_pixel_combine.sv
bench/testbench.sv
